// ===== rtl/mfw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared types, constants and lookup tables of the MPEG audio frame walker.
// ----------------------------------------------------------------------------
package mfw_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int TOTAL_BITS_DEF  = 32;

    localparam logic [23:0] FRAMES_MAX = 24'hFFFFFF;
    localparam logic [10:0] SYNC_WORD  = 11'h7FF;
    localparam logic [1:0]  VER_MPEG1  = 2'd3;
    localparam logic [1:0]  VER_RSVD   = 2'd1;
    localparam logic [1:0]  MODE_MONO  = 2'd3;
    localparam logic [3:0]  TAG_HDR_LEN = 4'd10;
    localparam logic [3:0]  TAG_SIZE_START = 4'd6;
    localparam logic [3:0]  MAGIC_LEN  = 4'd3;
    localparam logic [3:0]  HDR_LEN    = 4'd4;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        result_kind;
        logic [10:0] frame_bytes;
        logic [12:0] frame_pcm_bytes;
        logic [1:0]  frame_channels;
        logic [23:0] frame_count;
        logic [31:0] total_stream_bytes;
        logic [31:0] total_pcm_bytes;
        logic        stopped_bad_header;
        logic        last_result;
    } t_out_item;

    // event passed from the front to the back
    typedef struct packed {
        logic        has_frame;
        logic        has_end;
        logic        stop;
        logic [10:0] fb;
        logic [12:0] pcm;
        logic [1:0]  ch;
    } t_event;

    localparam logic RK_FRAME  = 1'b0;
    localparam logic RK_TOTALS = 1'b1;

    // "ID3" magic bytes
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h49;
            2'd1:    m = 8'h44;
            default: m = 8'h33;
        endcase
        return m;
    endfunction

    // bitrate in kbit/s; Layer III rows serve every layer
    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] bidx);
        logic [8:0] k;
        if (ver == VER_MPEG1) begin
            case (bidx)
                4'd1:    k = 9'd32;
                4'd2:    k = 9'd40;
                4'd3:    k = 9'd48;
                4'd4:    k = 9'd56;
                4'd5:    k = 9'd64;
                4'd6:    k = 9'd80;
                4'd7:    k = 9'd96;
                4'd8:    k = 9'd112;
                4'd9:    k = 9'd128;
                4'd10:   k = 9'd160;
                4'd11:   k = 9'd192;
                4'd12:   k = 9'd224;
                4'd13:   k = 9'd256;
                4'd14:   k = 9'd320;
                default: k = 9'd0;
            endcase
        end else if (ver == VER_RSVD) begin
            k = 9'd0;
        end else begin
            case (bidx)
                4'd1:    k = 9'd8;
                4'd2:    k = 9'd16;
                4'd3:    k = 9'd24;
                4'd4:    k = 9'd32;
                4'd5:    k = 9'd40;
                4'd6:    k = 9'd48;
                4'd7:    k = 9'd56;
                4'd8:    k = 9'd64;
                4'd9:    k = 9'd80;
                4'd10:   k = 9'd96;
                4'd11:   k = 9'd112;
                4'd12:   k = 9'd128;
                4'd13:   k = 9'd144;
                4'd14:   k = 9'd160;
                default: k = 9'd0;
            endcase
        end
        return k;
    endfunction

    // sample rate in Hz
    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] fidx);
        logic [15:0] r;
        case ({ver, fidx})
            4'b0000: r = 16'd11025;
            4'b0001: r = 16'd12000;
            4'b0010: r = 16'd8000;
            4'b1000: r = 16'd22050;
            4'b1001: r = 16'd24000;
            4'b1010: r = 16'd16000;
            4'b1100: r = 16'd44100;
            4'b1101: r = 16'd48000;
            4'b1110: r = 16'd32000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // sync plus table validity of a complete header word
    function automatic logic hdr_ok(input logic [31:0] h);
        return (h[31:21] == SYNC_WORD)
            && (kbps_lookup(h[20:19], h[15:12]) != 9'd0)
            && (rate_lookup(h[20:19], h[11:10]) != 16'd0);
    endfunction

endpackage : mfw_pkg
`default_nettype wire

// ===== rtl/mfw_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfw_div
// Restoring divider, one quotient bit per cycle, 11-bit quotient.
// ----------------------------------------------------------------------------
module mfw_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [25:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [10:0]      o_quo
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [25:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [10:0] r_quo, n_quo;
    logic [26:0] trial;

    // one compare and subtract per step, MSB first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        trial  = 27'(r_den) << r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd10;
            n_rem  = i_num;
            n_den  = i_den;
            n_quo  = '0;
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= trial) begin
                n_rem        = r_rem - trial[25:0];
                n_quo[r_cnt] = 1'b1;
            end
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule : mfw_div
`default_nettype wire

// ===== rtl/mfw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfw_front
// Byte classifier: tag skip, header assembly, frame body skip, frame length.
// ----------------------------------------------------------------------------
module mfw_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mfw_pkg::t_in_item i_item,
    output logic                   o_full,
    input  wire logic              i_q_full,
    output logic                   o_ev_push,
    output mfw_pkg::t_event        o_ev
);
    import mfw_pkg::*;

    typedef enum logic [5:0] {
        PH_TAG     = 6'b000001,
        PH_HEADER  = 6'b000010,
        PH_SKIP    = 6'b000100,
        PH_STOPPED = 6'b001000,
        PH_CALC    = 6'b010000,
        PH_EMIT    = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [3:0]  r_idx, n_idx;
    logic [28:0] r_skip, n_skip;
    logic        r_stopped, n_stopped;
    logic        r_pend_last, n_pend_last;
    logic        r_pend_stop, n_pend_stop;
    logic [10:0] r_fb, n_fb;

    logic        accept;
    logic [7:0]  b;
    logic        stop;
    logic [28:0] skip_dec;
    logic        div_start;
    logic [25:0] num_full;
    logic        div_done;
    logic [10:0] div_quo;
    logic [1:0]  ch;
    logic [12:0] pcm;

    assign o_full = i_q_full || (r_phase == PH_CALC) || (r_phase == PH_EMIT);
    assign accept = i_push && !o_full;
    assign b      = i_item.data_byte;
    assign skip_dec = r_skip - 29'(r_skip != '0);

    // numerator of the frame length from the completed header
    assign num_full = 26'(kbps_lookup(n_shift[20:19], n_shift[15:12]))
                    * ((n_shift[20:19] == VER_MPEG1) ? 26'd144000 : 26'd72000);

    mfw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_full),
        .i_den   (rate_lookup(n_shift[20:19], n_shift[11:10])),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // channels and PCM size of the held header
    assign ch  = (r_shift[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    always_comb begin
        case ({r_shift[20:19] == VER_MPEG1, ch == 2'd1})
            2'b11:   pcm = 13'd2304;
            2'b10:   pcm = 13'd4608;
            2'b01:   pcm = 13'd1152;
            default: pcm = 13'd2304;
        endcase
    end

    // byte walker
    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_idx       = r_idx;
        n_skip      = r_skip;
        n_stopped   = r_stopped;
        n_pend_last = r_pend_last;
        n_pend_stop = r_pend_stop;
        n_fb        = r_fb;
        div_start   = 1'b0;
        o_ev_push   = 1'b0;
        o_ev        = '0;
        stop        = 1'b0;

        case (r_phase)
            PH_CALC: begin
                if (div_done) begin
                    n_fb    = div_quo + 11'(r_shift[9]);
                    n_phase = PH_EMIT;
                end
            end
            PH_EMIT: begin
                if (!i_q_full) begin
                    o_ev_push      = 1'b1;
                    o_ev.has_frame = 1'b1;
                    o_ev.has_end   = r_pend_last;
                    o_ev.stop      = r_pend_stop;
                    o_ev.fb        = r_fb;
                    o_ev.pcm       = pcm;
                    o_ev.ch        = ch;
                    if (r_pend_last) begin
                        n_phase   = PH_TAG;
                        n_shift   = '0;
                        n_idx     = '0;
                        n_skip    = '0;
                        n_stopped = 1'b0;
                    end else begin
                        n_skip  = 29'(r_fb) - 29'd4;
                        n_phase = PH_SKIP;
                    end
                end
            end
            default: begin
                if (accept) begin
                    case (r_phase)
                        PH_TAG: begin
                            n_shift = {r_shift[23:0], b};
                            n_idx   = r_idx + 4'd1;
                            if (r_idx < MAGIC_LEN) begin
                                if (b != magic_byte(r_idx[1:0])) begin
                                    n_phase = PH_HEADER;
                                end
                            end else begin
                                if (r_idx >= TAG_SIZE_START) begin
                                    n_skip = {r_skip[21:0], b[6:0]};
                                end
                                if (n_idx >= TAG_HDR_LEN) begin
                                    n_idx   = '0;
                                    n_shift = '0;
                                    n_phase = (n_skip == '0) ? PH_HEADER : PH_SKIP;
                                end
                            end
                        end
                        PH_HEADER: begin
                            n_shift = {r_shift[23:0], b};
                            n_idx   = r_idx + 4'd1;
                            if (n_idx == HDR_LEN) begin
                                n_idx = '0;
                                if (hdr_ok(n_shift)) begin
                                    div_start = 1'b1;
                                    n_phase   = PH_CALC;
                                end else begin
                                    n_stopped = 1'b1;
                                    n_phase   = PH_STOPPED;
                                end
                            end
                        end
                        PH_SKIP: begin
                            n_skip = skip_dec;
                            if (skip_dec == '0) begin
                                n_shift = '0;
                                n_idx   = '0;
                                n_phase = PH_HEADER;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // end of stream
                    stop = n_stopped || (n_phase == PH_TAG)
                        || ((n_phase == PH_HEADER) && (n_idx != '0));
                    n_pend_last = i_item.last_byte;
                    n_pend_stop = stop;
                    if (i_item.last_byte && (n_phase != PH_CALC)) begin
                        o_ev_push    = 1'b1;
                        o_ev.has_end = 1'b1;
                        o_ev.stop    = stop;
                        n_phase      = PH_TAG;
                        n_shift      = '0;
                        n_idx        = '0;
                        n_skip       = '0;
                        n_stopped    = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_shift     <= '0;
            r_idx       <= '0;
            r_skip      <= '0;
            r_stopped   <= 1'b0;
            r_pend_last <= 1'b0;
            r_pend_stop <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_idx       <= n_idx;
            r_skip      <= n_skip;
            r_stopped   <= n_stopped;
            r_pend_last <= n_pend_last;
            r_pend_stop <= n_pend_stop;
        end
        r_fb <= n_fb;
    end

endmodule : mfw_front
`default_nettype wire

// ===== rtl/mfw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfw_queue
// Short event queue between the front and the back.
// ----------------------------------------------------------------------------
module mfw_queue #(
    parameter int DEPTH = mfw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mfw_pkg::t_event i_ev,
    output logic                 o_full,
    input  wire logic            i_pop,
    output mfw_pkg::t_event      o_ev,
    output logic                 o_empty
);
    import mfw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ev    = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_ev;
        end
    end

endmodule : mfw_queue
`default_nettype wire

// ===== rtl/mfw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfw_back
// Totals accumulation and result register.
// ----------------------------------------------------------------------------
module mfw_back #(
    parameter int TOTAL_BITS = mfw_pkg::TOTAL_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mfw_pkg::t_event i_ev,
    input  wire logic            i_ev_valid,
    output logic                 o_ev_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output mfw_pkg::t_out_item   o_item
);
    import mfw_pkg::*;

    localparam logic [32:0] CAP = (TOTAL_BITS >= 32) ? 33'h0FFFFFFFF
                                : ((33'd1 << TOTAL_BITS) - 33'd1);

    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic [23:0] r_frames, n_frames;
    logic [31:0] r_stream, n_stream;
    logic [31:0] r_pcm, n_pcm;
    logic        r_end_pend, n_end_pend;
    logic        r_end_stop, n_end_stop;

    logic        can_load;
    logic [23:0] f_frames;
    logic [32:0] s_stream, s_pcm;
    logic [31:0] f_stream, f_pcm;

    // saturating updates for a frame
    assign f_frames = r_frames + 24'(r_frames != FRAMES_MAX);
    assign s_stream = {1'b0, r_stream} + 33'(i_ev.fb);
    assign s_pcm    = {1'b0, r_pcm} + 33'(i_ev.pcm);
    assign f_stream = (s_stream > CAP) ? CAP[31:0] : s_stream[31:0];
    assign f_pcm    = (s_pcm > CAP) ? CAP[31:0] : s_pcm[31:0];

    assign can_load = !r_out_valid || i_pop;

    // result loading
    always_comb begin
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_frames    = r_frames;
        n_stream    = r_stream;
        n_pcm       = r_pcm;
        n_end_pend  = r_end_pend;
        n_end_stop  = r_end_stop;
        o_ev_pop    = 1'b0;
        if (can_load) begin
            if (r_end_pend) begin
                n_out_valid = 1'b1;
                n_out       = '0;
                n_out.result_kind        = RK_TOTALS;
                n_out.frame_count        = r_frames;
                n_out.total_stream_bytes = r_stream;
                n_out.total_pcm_bytes    = r_pcm;
                n_out.stopped_bad_header = r_end_stop;
                n_out.last_result        = 1'b1;
                n_frames   = '0;
                n_stream   = '0;
                n_pcm      = '0;
                n_end_pend = 1'b0;
            end else if (i_ev_valid) begin
                o_ev_pop    = 1'b1;
                n_out_valid = 1'b1;
                n_out       = '0;
                if (i_ev.has_frame) begin
                    n_frames = f_frames;
                    n_stream = f_stream;
                    n_pcm    = f_pcm;
                    n_out.result_kind        = RK_FRAME;
                    n_out.frame_bytes        = i_ev.fb;
                    n_out.frame_pcm_bytes    = i_ev.pcm;
                    n_out.frame_channels     = i_ev.ch;
                    n_out.frame_count        = f_frames;
                    n_out.total_stream_bytes = f_stream;
                    n_out.total_pcm_bytes    = f_pcm;
                    n_out.last_result        = !i_ev.has_end;
                    n_end_pend = i_ev.has_end;
                    n_end_stop = i_ev.stop;
                end else begin
                    n_out.result_kind        = RK_TOTALS;
                    n_out.frame_count        = r_frames;
                    n_out.total_stream_bytes = r_stream;
                    n_out.total_pcm_bytes    = r_pcm;
                    n_out.stopped_bad_header = i_ev.stop;
                    n_out.last_result        = 1'b1;
                    n_frames = '0;
                    n_stream = '0;
                    n_pcm    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_frames    <= '0;
            r_stream    <= '0;
            r_pcm       <= '0;
            r_end_pend  <= 1'b0;
            r_end_stop  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_frames    <= n_frames;
            r_stream    <= n_stream;
            r_pcm       <= n_pcm;
            r_end_pend  <= n_end_pend;
            r_end_stop  <= n_end_stop;
        end
        r_out <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    // checks
    a_frame_no_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == RK_FRAME) |-> !r_out.stopped_bad_header)
        else $error("frame result carries stop flag");
    a_totals_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == RK_TOTALS)
            |-> (r_out.last_result && r_out.frame_bytes == '0))
        else $error("malformed totals result");
    a_pend_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_pend |-> (r_out_valid && r_out.result_kind == RK_FRAME))
        else $error("pending totals without waiting frame result");

endmodule : mfw_back
`default_nettype wire

// ===== rtl/mp3_frame_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp3_frame_walker
// MPEG audio frame walker: per-frame info and end-of-stream totals.
// ----------------------------------------------------------------------------
// Input channel: push/full, one stream byte per transaction with a last-byte
// flag. Result channel: empty/pop, oldest result on o_item while empty is low.
// Tag bytes and frame body bytes are taken one per cycle while the event
// queue has room. When the fourth header byte completes a valid header,
// full stays high while the 11-step restoring divider works out the frame
// length and the frame event is queued. A frame result then passes the
// event queue and the result register; a totals result passes the event
// queue and the result register, when the result register is free.
// A two-entry event queue and the result register let the input keep
// running while results wait; when the receiver stalls, the queue fills and
// full rises. A valid header on the last byte yields two results, frame then
// totals. Reset (synchronous, active low) returns to the start-of-stream
// state, clears totals and drops pending results; no clearing pass.
// ----------------------------------------------------------------------------
module mp3_frame_walker #(
    parameter int TOTAL_BITS  = mfw_pkg::TOTAL_BITS_DEF,
    parameter int QUEUE_DEPTH = mfw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    input  wire mfw_pkg::t_in_item   i_item,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output mfw_pkg::t_out_item       o_item
);
    import mfw_pkg::*;

    t_event q_in_ev, q_out_ev;
    logic   q_push, q_full, q_pop, q_empty;

    mfw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_q_full  (q_full),
        .o_ev_push (q_push),
        .o_ev      (q_in_ev)
    );

    mfw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ev    (q_in_ev),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_ev    (q_out_ev),
        .o_empty (q_empty)
    );

    mfw_back #(.TOTAL_BITS(TOTAL_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (q_out_ev),
        .i_ev_valid (!q_empty),
        .o_ev_pop   (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_item     (o_item)
    );

endmodule : mp3_frame_walker
`default_nettype wire
